// ===== design/mmee_pkg.sv =====
package mmee_pkg;

	// field widths
	localparam int MOM_W   = 24;
	localparam int SLOPE_W = 16;
	localparam int ERR_W   = 32;
	localparam int RATIO_W = 16;
	localparam int MODE_W  = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A_Z = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd4;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;

	// mode bits
	localparam int MODE_AZIMUTH = 0;
	localparam int MODE_CHAMBER = 1;
	localparam int MODE_AVERAGE = 2;
	localparam int MODE_USE_OUT = 3;
	localparam int MODE_SQUARE  = 4;

	localparam logic [MOM_W-1:0] MOM_MAX = 24'hFF_FFFF;
	localparam logic [ERR_W-1:0] ERR_MAX = 32'hFFFF_FFFF;

	// azimuthal fit constants, q2.30, factor 1.58 folded in
	localparam logic [31:0] AZ_K1   = 32'd1191290784;
	localparam logic [31:0] AZ_K2   = 32'd3529932689;
	localparam logic [31:0] AZ_K3   = 32'd196286448;
	localparam logic [31:0] AZ_QMIN = 32'd612032840;

	// floor(x/1000) = (x*RECIP_1000) >> 38 for any 32-bit x
	localparam logic [28:0] RECIP_1000 = 29'd274877907;
	localparam logic [9:0]  THOUSAND   = 10'd1000;

	// iteration counts
	localparam int RD_N = 24; // ratio divide quotient bits
	localparam int CD_N = 31; // cos^2 divide quotient bits
	localparam int CS_N = 31; // cos root bits
	localparam int QD_N = 33; // 2^62/q quotient bits
	localparam int QS_N = 17; // momentum root bits
	localparam int LD_N = 32; // error divide quotient bits
	localparam int LS_N = 32; // error root bits

	localparam int A_LAT   = 7 + RD_N + CD_N + CS_N + QD_N + QS_N;
	localparam int LN_LAT  = 7 + LD_N + LS_N;
	localparam int TOT_LAT = A_LAT + LN_LAT + 1;

	typedef struct packed {
		logic [MOM_W-1:0]          momentum_in;
		logic [MOM_W-1:0]          momentum_out;
		logic signed [SLOPE_W-1:0] slope_in_x;
		logic signed [SLOPE_W-1:0] slope_in_z;
		logic signed [SLOPE_W-1:0] slope_out_x;
		logic signed [SLOPE_W-1:0] slope_out_z;
	} in_word_t;

	typedef struct packed {
		logic [MOM_W-1:0] result_momentum;
		logic [MOM_W-1:0] result_momentum_out;
		logic [ERR_W-1:0] err_in_x;
		logic [ERR_W-1:0] err_in_z;
		logic [ERR_W-1:0] err_out_x;
		logic [ERR_W-1:0] err_out_z;
		logic             divide_fault;
	} out_word_t;

	// square of a signed q4.12 slope, q8.24
	function automatic logic [30:0] slope_sq(input logic [SLOPE_W-1:0] s);
		logic [SLOPE_W-1:0] mag;
		logic [31:0] p;
		mag = s[SLOPE_W-1] ? 16'(~s + 16'd1) : s;
		p = 32'(mag) * 32'(mag);
		return p[30:0];
	endfunction

endpackage

// ===== design/mmee_lane.sv =====
module mmee_lane import mmee_pkg::*; (
	input  logic                     clk,
	input  logic                     adv,
	input  logic [MOM_W-1:0]         coeff,
	input  logic [MOM_W-1:0]         mom,
	input  logic [SLOPE_W-1:0]       slope,
	input  logic [45:0]              v2,
	input  logic                     square_mode,
	input  logic                     chamber_mode,
	output logic [ERR_W-1:0]         err,
	output logic                     fault
);

	typedef struct packed {
		logic        zero;
		logic [30:0] fac;
		logic        usat;
		logic        ovf;
		logic [31:0] u;
	} ln_ctx_t;

	// divisor 1000*p and slope factor
	logic [33:0]      dv_s1;
	logic [MOM_W-1:0] a_s1;
	ln_ctx_t          ctx_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s1  <= 34'(mom) * 34'(THOUSAND);
			a_s1   <= coeff;
			ctx_s1 <= '{zero: (mom == '0), fac: 31'h100_0000 + slope_sq(slope),
				usat: 1'b0, ovf: 1'b0, u: '0};
		end
	end

	// long division a*2^24 / (1000*p)
	logic [33:0]      ld_rem_s [LD_N+1];
	logic [31:0]      ld_quo_s [LD_N+1];
	logic [33:0]      ld_dv_s  [LD_N+1];
	logic [7:0]       ld_lo_s  [LD_N+1];
	logic             ld_sat_s [LD_N+1];
	ln_ctx_t          ld_ctx_s [LD_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			ld_rem_s[0] <= {18'd0, a_s1[23:8]};
			ld_quo_s[0] <= '0;
			ld_dv_s[0]  <= dv_s1;
			ld_lo_s[0]  <= a_s1[7:0];
			ld_sat_s[0] <= {18'd0, a_s1} >= {dv_s1, 8'd0};
			ld_ctx_s[0] <= ctx_s1;
		end
	end

	for (genvar k = 0; k < LD_N; k++) begin : g_div
		logic        bt;
		logic [34:0] t;
		logic        ge;
		if (k < 8) begin : g_lo
			assign bt = ld_lo_s[k][7-k];
		end else begin : g_zero
			assign bt = 1'b0;
		end
		assign t  = {ld_rem_s[k], bt};
		assign ge = t >= {1'b0, ld_dv_s[k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				ld_rem_s[k+1] <= ge ? 34'(t - {1'b0, ld_dv_s[k]}) : t[33:0];
				ld_quo_s[k+1] <= {ld_quo_s[k][30:0], ge};
				ld_dv_s[k+1]  <= ld_dv_s[k];
				ld_lo_s[k+1]  <= ld_lo_s[k];
				ld_sat_s[k+1] <= ld_sat_s[k];
				ld_ctx_s[k+1] <= ld_ctx_s[k];
			end
		end
	end

	// u and its square
	logic [31:0] u_c;
	logic [63:0] u2_s2;
	ln_ctx_t     ctx_s2;

	assign u_c = ld_sat_s[LD_N] ? ERR_MAX : ld_quo_s[LD_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			u2_s2  <= 64'(u_c) * 64'(u_c);
			ctx_s2 <= '{zero: ld_ctx_s[LD_N].zero, fac: ld_ctx_s[LD_N].fac,
				usat: ld_sat_s[LD_N], ovf: 1'b0, u: u_c};
		end
	end

	// u^2 + v^2, then square root
	logic [64:0] sum_c;
	logic [33:0] ls_rem_s  [LS_N+1];
	logic [31:0] ls_root_s [LS_N+1];
	logic [63:0] ls_x_s    [LS_N+1];
	ln_ctx_t     ls_ctx_s  [LS_N+1];

	assign sum_c = 65'(u2_s2) + 65'(v2);

	always_ff @(posedge clk) begin
		if (adv) begin
			ls_rem_s[0]  <= '0;
			ls_root_s[0] <= '0;
			ls_x_s[0]    <= sum_c[63:0];
			ls_ctx_s[0]  <= '{zero: ctx_s2.zero, fac: ctx_s2.fac, usat: ctx_s2.usat,
				ovf: sum_c[64], u: ctx_s2.u};
		end
	end

	for (genvar j = 0; j < LS_N; j++) begin : g_sqrt
		logic [35:0] t;
		logic [35:0] trial;
		logic        ge;
		assign t     = {ls_rem_s[j], ls_x_s[j][63-2*j -: 2]};
		assign trial = {2'b00, ls_root_s[j], 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				ls_rem_s[j+1]  <= ge ? 34'(t - trial) : t[33:0];
				ls_root_s[j+1] <= {ls_root_s[j][30:0], ge};
				ls_x_s[j+1]    <= ls_x_s[j];
				ls_ctx_s[j+1]  <= ls_ctx_s[j];
			end
		end
	end

	// select linear or square error
	logic [31:0] e_s3;
	logic [30:0] fac_s3;
	logic        zero_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ls_ctx_s[LS_N].usat) begin
				e_s3 <= ERR_MAX;
			end else if (square_mode) begin
				e_s3 <= ls_ctx_s[LS_N].ovf ? ERR_MAX : ls_root_s[LS_N];
			end else begin
				e_s3 <= ls_ctx_s[LS_N].u;
			end
			fac_s3  <= ls_ctx_s[LS_N].fac;
			zero_s3 <= ls_ctx_s[LS_N].zero;
		end
	end

	// chamber slope scaling
	logic [62:0] prod_s4;
	logic [31:0] e_s4;
	logic        zero_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= 63'(e_s3) * 63'(fac_s3);
			e_s4    <= e_s3;
			zero_s4 <= zero_s3;
		end
	end

	logic [38:0] sh_c;
	logic [31:0] ec_c;

	assign sh_c = prod_s4[62:24];
	assign ec_c = (|sh_c[38:32]) ? ERR_MAX : sh_c[31:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_s4) begin
				err <= ERR_MAX;
			end else begin
				err <= chamber_mode ? ec_c : e_s4;
			end
			fault <= zero_s4;
		end
	end

endmodule

// ===== design/muon_momentum_error_estimator_top.sv =====
// channel   | signals                                 | role
// ----------+-----------------------------------------+--------------------------------
// item      | item_valid, item_stall, item            | event word in, in_word_t
// result    | result_valid, result_stall, result      | momenta, errors, fault out
// cfg       | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// one word per cycle unless the output word is stalled; latency is set by the chain of
// one-bit-per-stage dividers and square roots (ratio divide, cos^2 divide, cos root,
// 2^62/q divide and momentum root, then per-error divide and root in four parallel lanes)
// arst_n clears the valid bits and the registers, payload stages keep no reset
// the whole pipe holds when the output word is stalled, item_stall follows it
module muon_momentum_error_estimator_top import mmee_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  in_word_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_word_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		in_word_t         it;
		logic             rsat;
		logic [RD_N-1:0]  rq;
	} actx_t;

	// configuration registers
	logic [MOM_W-1:0]   coeff_a_x_q;
	logic [MOM_W-1:0]   coeff_a_z_q;
	logic [MOM_W-1:0]   coeff_b_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [MODE_W-1:0]  mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_x_q <= '0;
			coeff_a_z_q <= '0;
			coeff_b_q   <= '0;
			ratio_q     <= RATIO_RESET;
			mode_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COEFF_A_X: coeff_a_x_q <= cfg_data;
				CFG_COEFF_A_Z: coeff_a_z_q <= cfg_data;
				CFG_COEFF_B:   coeff_b_q   <= cfg_data;
				CFG_RATIO:     ratio_q     <= cfg_data[RATIO_W-1:0];
				CFG_MODE:      mode_q      <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// constant error term b/1000 in q8.24 and its square, follow coeff_b
	logic [60:0] vprod_c;
	logic [22:0] v_q;
	logic [45:0] v2_q;

	assign vprod_c = 61'({coeff_b_q, 8'd0}) * 61'(RECIP_1000);

	always_ff @(posedge clk) begin
		v_q  <= vprod_c[60:38];
		v2_q <= 46'(v_q) * 46'(v_q);
	end

	// pipeline advance and valid bits
	logic adv;
	logic [TOT_LAT:1] vld_s;

	assign adv        = !(vld_s[TOT_LAT] && result_stall);
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[TOT_LAT-1:1], item_valid};
		end
	end

	// ratio divide pin*4096/ratio, entry also squares the slopes
	actx_t               rd_ctx_s [RD_N+1];
	logic [RATIO_W-1:0]  rd_rem_s [RD_N+1];
	logic [RD_N-1:0]     rd_quo_s [RD_N+1];
	logic [30:0]         rd_sqx_s [RD_N+1];
	logic [30:0]         rd_sqz_s [RD_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_ctx_s[0] <= '{it: item,
				rsat: {4'd0, item.momentum_in} >= {ratio_q, 12'd0}, rq: '0};
			rd_rem_s[0] <= {4'd0, item.momentum_in[23:12]};
			rd_quo_s[0] <= '0;
			rd_sqx_s[0] <= slope_sq(item.slope_in_x);
			rd_sqz_s[0] <= slope_sq(item.slope_in_z);
		end
	end

	for (genvar k = 0; k < RD_N; k++) begin : g_rdiv
		logic        bt;
		logic [16:0] t;
		logic        ge;
		if (k < 12) begin : g_lo
			assign bt = rd_ctx_s[k].it.momentum_in[11-k];
		end else begin : g_zero
			assign bt = 1'b0;
		end
		assign t  = {rd_rem_s[k], bt};
		assign ge = t >= {1'b0, ratio_q};
		always_ff @(posedge clk) begin
			if (adv) begin
				rd_rem_s[k+1] <= ge ? 16'(t - {1'b0, ratio_q}) : t[15:0];
				rd_quo_s[k+1] <= {rd_quo_s[k][RD_N-2:0], ge};
				rd_ctx_s[k+1] <= rd_ctx_s[k];
				rd_sqx_s[k+1] <= rd_sqx_s[k];
				rd_sqz_s[k+1] <= rd_sqz_s[k];
			end
		end
	end

	// cos^2 = 2^54 / (2^24 + sx^2 + sz^2)
	actx_t        cd_ctx_s [CD_N+1];
	logic [31:0]  cd_d_s   [CD_N+1];
	logic [31:0]  cd_rem_s [CD_N+1];
	logic [CD_N-1:0] cd_quo_s [CD_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cd_ctx_s[0] <= '{it: rd_ctx_s[RD_N].it, rsat: rd_ctx_s[RD_N].rsat,
				rq: rd_quo_s[RD_N]};
			cd_d_s[0]   <= 32'h0100_0000 + {1'b0, rd_sqx_s[RD_N]} + {1'b0, rd_sqz_s[RD_N]};
			cd_rem_s[0] <= 32'h0080_0000;
			cd_quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < CD_N; k++) begin : g_cdiv
		logic [32:0] t;
		logic        ge;
		assign t  = {cd_rem_s[k], 1'b0};
		assign ge = t >= {1'b0, cd_d_s[k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				cd_rem_s[k+1] <= ge ? 32'(t - {1'b0, cd_d_s[k]}) : t[31:0];
				cd_quo_s[k+1] <= {cd_quo_s[k][CD_N-2:0], ge};
				cd_d_s[k+1]   <= cd_d_s[k];
				cd_ctx_s[k+1] <= cd_ctx_s[k];
			end
		end
	end

	// c = sqrt(cos^2 * 2^30)
	actx_t        cs_ctx_s  [CS_N+1];
	logic [32:0]  cs_rem_s  [CS_N+1];
	logic [30:0]  cs_root_s [CS_N+1];
	logic [30:0]  cs_csq_s  [CS_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_ctx_s[0]  <= cd_ctx_s[CD_N];
			cs_rem_s[0]  <= '0;
			cs_root_s[0] <= '0;
			cs_csq_s[0]  <= cd_quo_s[CD_N];
		end
	end

	for (genvar j = 0; j < CS_N; j++) begin : g_csqrt
		logic [61:0] xw;
		logic [34:0] t;
		logic [34:0] trial;
		logic        ge;
		assign xw    = {1'b0, cs_csq_s[j], 30'd0};
		assign t     = {cs_rem_s[j], xw[61-2*j -: 2]};
		assign trial = {2'b00, cs_root_s[j], 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				cs_rem_s[j+1]  <= ge ? 33'(t - trial) : t[32:0];
				cs_root_s[j+1] <= {cs_root_s[j][29:0], ge};
				cs_csq_s[j+1]  <= cs_csq_s[j];
				cs_ctx_s[j+1]  <= cs_ctx_s[j];
			end
		end
	end

	// quadratic terms K2*c and K1*c^2
	logic [62:0] pp_c;
	logic [61:0] np_c;
	logic [31:0] pm_s1;
	logic [31:0] nm_s1;
	actx_t       mul_ctx_s1;

	assign pp_c = 63'(AZ_K2) * 63'(cs_root_s[CS_N]);
	assign np_c = 62'(AZ_K1) * 62'(cs_csq_s[CS_N]);

	always_ff @(posedge clk) begin
		if (adv) begin
			pm_s1      <= pp_c[61:30];
			nm_s1      <= np_c[61:30];
			mul_ctx_s1 <= cs_ctx_s[CS_N];
		end
	end

	// q, clamped at qmin, then 2^62 / q
	logic [31:0] pos_c;
	logic [31:0] qd_c;
	logic [31:0] q_c;

	assign pos_c = 32'(pm_s1 + AZ_K3);
	assign qd_c  = (pos_c > nm_s1) ? 32'(pos_c - nm_s1) : 32'd0;
	assign q_c   = (qd_c < AZ_QMIN) ? AZ_QMIN : qd_c;

	actx_t           qd_ctx_s [QD_N+1];
	logic [31:0]     qd_d_s   [QD_N+1];
	logic [31:0]     qd_rem_s [QD_N+1];
	logic [QD_N-1:0] qd_quo_s [QD_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			qd_ctx_s[0] <= mul_ctx_s1;
			qd_d_s[0]   <= q_c;
			qd_rem_s[0] <= 32'h2000_0000;
			qd_quo_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < QD_N; k++) begin : g_qdiv
		logic [32:0] t;
		logic        ge;
		assign t  = {qd_rem_s[k], 1'b0};
		assign ge = t >= {1'b0, qd_d_s[k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				qd_rem_s[k+1] <= ge ? 32'(t - {1'b0, qd_d_s[k]}) : t[31:0];
				qd_quo_s[k+1] <= {qd_quo_s[k][QD_N-2:0], ge};
				qd_d_s[k+1]   <= qd_d_s[k];
				qd_ctx_s[k+1] <= qd_ctx_s[k];
			end
		end
	end

	// estimated outgoing momentum = sqrt(2^62 / q)
	actx_t       qs_ctx_s  [QS_N+1];
	logic [18:0] qs_rem_s  [QS_N+1];
	logic [16:0] qs_root_s [QS_N+1];
	logic [QD_N-1:0] qs_x_s [QS_N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			qs_ctx_s[0]  <= qd_ctx_s[QD_N];
			qs_rem_s[0]  <= '0;
			qs_root_s[0] <= '0;
			qs_x_s[0]    <= qd_quo_s[QD_N];
		end
	end

	for (genvar j = 0; j < QS_N; j++) begin : g_qsqrt
		logic [33:0] xw;
		logic [20:0] t;
		logic [20:0] trial;
		logic        ge;
		assign xw    = {1'b0, qs_x_s[j]};
		assign t     = {qs_rem_s[j], xw[33-2*j -: 2]};
		assign trial = {2'b00, qs_root_s[j], 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (adv) begin
				qs_rem_s[j+1]  <= ge ? 19'(t - trial) : t[18:0];
				qs_root_s[j+1] <= {qs_root_s[j][15:0], ge};
				qs_x_s[j+1]    <= qs_x_s[j];
				qs_ctx_s[j+1]  <= qs_ctx_s[j];
			end
		end
	end

	// pick incoming and outgoing momenta
	actx_t            sc;
	logic [MOM_W-1:0] pin_c;
	logic [MOM_W-1:0] pout_c;
	logic             fault_c;
	logic [39:0]      rp_c;

	assign sc = qs_ctx_s[QS_N];

	always_comb begin
		pin_c   = sc.it.momentum_in;
		pout_c  = sc.it.momentum_out;
		fault_c = 1'b0;
		rp_c    = '0;
		if (sc.it.momentum_in != '0) begin
			if (sc.it.momentum_out == '0) begin
				if (ratio_q == '0) begin
					pout_c  = MOM_MAX;
					fault_c = 1'b1;
				end else begin
					pout_c = sc.rsat ? MOM_MAX : sc.rq;
				end
			end
		end else begin
			if (mode_q[MODE_AZIMUTH]) begin
				pout_c = {7'd0, qs_root_s[QS_N]};
			end
			rp_c  = 40'(pout_c) * 40'(ratio_q);
			pin_c = (|rp_c[39:36]) ? MOM_MAX : rp_c[35:12];
		end
	end

	logic [MOM_W-1:0] dl_pin_s   [LN_LAT+1];
	logic [MOM_W-1:0] dl_pout_s  [LN_LAT+1];
	logic             dl_fault_s [LN_LAT+1];
	in_word_t         sel_it_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_pin_s[0]   <= pin_c;
			dl_pout_s[0]  <= pout_c;
			dl_fault_s[0] <= fault_c;
			sel_it_s1     <= sc.it;
		end
	end

	// momenta wait alongside the error lanes
	for (genvar k = 0; k < LN_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				dl_pin_s[k+1]   <= dl_pin_s[k];
				dl_pout_s[k+1]  <= dl_pout_s[k];
				dl_fault_s[k+1] <= dl_fault_s[k];
			end
		end
	end

	// four slope-error lanes
	logic [ERR_W-1:0] err_in_x_c, err_in_z_c, err_out_x_c, err_out_z_c;
	logic [3:0]       lane_fault;

	mmee_lane u_in_x (
		.clk(clk), .adv(adv), .coeff(coeff_a_x_q), .mom(dl_pin_s[0]),
		.slope(sel_it_s1.slope_in_x), .v2(v2_q), .square_mode(mode_q[MODE_SQUARE]),
		.chamber_mode(mode_q[MODE_CHAMBER]), .err(err_in_x_c), .fault(lane_fault[0])
	);

	mmee_lane u_in_z (
		.clk(clk), .adv(adv), .coeff(coeff_a_z_q), .mom(dl_pin_s[0]),
		.slope(sel_it_s1.slope_in_z), .v2(v2_q), .square_mode(mode_q[MODE_SQUARE]),
		.chamber_mode(mode_q[MODE_CHAMBER]), .err(err_in_z_c), .fault(lane_fault[1])
	);

	mmee_lane u_out_x (
		.clk(clk), .adv(adv), .coeff(coeff_a_x_q), .mom(dl_pout_s[0]),
		.slope(sel_it_s1.slope_out_x), .v2(v2_q), .square_mode(mode_q[MODE_SQUARE]),
		.chamber_mode(mode_q[MODE_CHAMBER]), .err(err_out_x_c), .fault(lane_fault[2])
	);

	mmee_lane u_out_z (
		.clk(clk), .adv(adv), .coeff(coeff_a_z_q), .mom(dl_pout_s[0]),
		.slope(sel_it_s1.slope_out_z), .v2(v2_q), .square_mode(mode_q[MODE_SQUARE]),
		.chamber_mode(mode_q[MODE_CHAMBER]), .err(err_out_z_c), .fault(lane_fault[3])
	);

	// final momentum: use-outgoing wins over averaging
	logic [MOM_W:0]   avg_sum_c;
	logic [MOM_W-1:0] fin_c;

	assign avg_sum_c = {1'b0, dl_pin_s[LN_LAT]} + {1'b0, dl_pout_s[LN_LAT]};

	always_comb begin
		fin_c = dl_pin_s[LN_LAT];
		if (mode_q[MODE_USE_OUT]) begin
			fin_c = dl_pout_s[LN_LAT];
		end else if (mode_q[MODE_AVERAGE]) begin
			fin_c = avg_sum_c[MOM_W:1];
		end
	end

	out_word_t result_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= '{result_momentum: fin_c,
				result_momentum_out: dl_pout_s[LN_LAT],
				err_in_x: err_in_x_c, err_in_z: err_in_z_c,
				err_out_x: err_out_x_c, err_out_z: err_out_z_c,
				divide_fault: dl_fault_s[LN_LAT] | (|lane_fault)};
		end
	end

	assign result       = result_q;
	assign result_valid = vld_s[TOT_LAT];

endmodule

// ===== design/mmee_checker.sv =====
module mmee_checker import mmee_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_stall,
	input logic                  result_valid,
	input logic                  result_stall,
	input out_word_t             result
);

	// a stalled result word stays
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// a held output freezes the whole pipe, so the input is stalled too
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("input taken while output held");

	// a zero divisor always leaves a saturated field
	a_fault_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.divide_fault |->
			(result.result_momentum_out == MOM_MAX) || (result.err_in_x == ERR_MAX) ||
			(result.err_in_z == ERR_MAX) || (result.err_out_x == ERR_MAX) ||
			(result.err_out_z == ERR_MAX))
		else $error("divide fault without saturated field");

endmodule

bind muon_momentum_error_estimator_top mmee_checker u_mmee_checker (.*);
